[src/cftp_pkg.sv]
// Package for the three-point circle unit: widths, types and lane codes.
// Used by every module of the block; depends on nothing.
package cftp_pkg;

    // Input and fixed-point format
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 8;

    // Derived arithmetic widths
    localparam int DIFF_BITS  = COORD_BITS + 1;              // point differences
    localparam int PROD_BITS  = 2 * DIFF_BITS;               // difference products
    localparam int DET_BITS   = PROD_BITS + 1;               // signed determinant
    localparam int LEN_BITS   = 2 * (DIFF_BITS - 1) + 1;     // squared lengths
    localparam int NX_BITS    = DIFF_BITS + LEN_BITS + 1;    // signed center numerators
    localparam int MAG_BITS   = NX_BITS - 1;                 // numerator magnitude
    localparam int DMAG_BITS  = DET_BITS - 1;                // determinant magnitude
    localparam int HALF_BITS  = (MAG_BITS + 1) / 2;          // low part of a split square
    localparam int HI_BITS    = MAG_BITS - HALF_BITS;        // high part of a split square
    localparam int PP_BITS    = 2 * HALF_BITS;               // partial product
    localparam int SQ_BITS    = 2 * MAG_BITS;                // squared numerator
    localparam int DSQ_BITS   = 2 * DMAG_BITS;               // squared determinant
    localparam int NUM_BITS   = SQ_BITS + 1 + 2 * FRAC_BITS; // dividend
    localparam int DEN_BITS   = DSQ_BITS + 2;                // divisor
    localparam int QUO_BITS   = 64;                          // quotient
    localparam int REM_BITS   = QUO_BITS + DEN_BITS;         // partial remainder
    localparam int ROOT_BITS  = QUO_BITS / 2;                // square root
    localparam int SREM_BITS  = ROOT_BITS + 3;               // root remainder
    localparam int VAL_BITS   = 64;                          // center before saturation
    localparam int OUT_BITS   = 32;                          // result word fields

    // Lanes of the shared divider
    localparam int LANE_S = 0;
    localparam int LANE_T = 1;
    localparam int LANE_R = 2;
    localparam int NLANE  = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [DET_BITS-1:0]   det_t;
    typedef logic        [LEN_BITS-1:0]   len_t;
    typedef logic signed [NX_BITS-1:0]    nx_t;
    typedef logic        [MAG_BITS-1:0]   mag_t;
    typedef logic        [DMAG_BITS-1:0]  dmag_t;
    typedef logic        [PP_BITS-1:0]    pp_t;
    typedef logic        [SQ_BITS-1:0]    sq_t;
    typedef logic        [DSQ_BITS-1:0]   dsq_t;
    typedef logic        [NUM_BITS-1:0]   num_t;
    typedef logic        [DEN_BITS-1:0]   den_t;
    typedef logic        [QUO_BITS-1:0]   quo_t;
    typedef logic        [REM_BITS-1:0]   rem_t;
    typedef logic        [ROOT_BITS-1:0]  root_t;
    typedef logic        [SREM_BITS-1:0]  srem_t;

    // Center quotient clamp
    localparam quo_t QCLAMP = quo_t'(1) << 40;

    // Per-word side data that rides along the divider
    typedef struct packed {
        coord_t s1;
        coord_t t1;
        logic   neg_s;
        logic   neg_t;
        logic   colin;
    } side_t;

    // Finished result word
    typedef struct packed {
        logic [OUT_BITS-1:0] center_s;
        logic [OUT_BITS-1:0] center_t;
        logic [OUT_BITS-1:0] radius;
        logic                colin;
        logic                ovf;
    } res_t;

endpackage

[src/cftp_front.sv]
// Front end of the circle unit: determinant, center numerators, squared terms
// and the dividends and divisors of the three divider lanes. Uses cftp_pkg.
module cftp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  cftp_pkg::coord_t       first_s,
    input  cftp_pkg::coord_t       first_t,
    input  cftp_pkg::coord_t       second_s,
    input  cftp_pkg::coord_t       second_t,
    input  cftp_pkg::coord_t       third_s,
    input  cftp_pkg::coord_t       third_t,
    output logic                   out_valid,
    output cftp_pkg::side_t        out_side,
    output cftp_pkg::num_t         out_num [cftp_pkg::NLANE],
    output cftp_pkg::den_t         out_den [cftp_pkg::NLANE]
);

    localparam int NSTG = 9;

    logic [NSTG:1] vld_reg;
    cftp_pkg::coord_t s1_reg [1:5];
    cftp_pkg::coord_t t1_reg [1:5];

    // stage 1..3 terms
    cftp_pkg::diff_t ax_reg [1:3];
    cftp_pkg::diff_t ay_reg [1:3];
    cftp_pkg::diff_t bx_reg [1:3];
    cftp_pkg::diff_t by_reg [1:3];
    cftp_pkg::prod_t axby_reg, aybx_reg, sqax_reg, sqay_reg, sqbx_reg, sqby_reg;
    cftp_pkg::det_t  det_reg [3:5];
    cftp_pkg::len_t  la_reg, lb_reg;
    cftp_pkg::nx_t   byla_reg, aylb_reg, axlb_reg, bxla_reg;
    cftp_pkg::nx_t   nx_reg, ny_reg;

    // stage 6..8 terms
    cftp_pkg::side_t side_reg [6:8];
    cftp_pkg::mag_t  mnx_reg [6:8];
    cftp_pkg::mag_t  mny_reg [6:8];
    cftp_pkg::dmag_t mdet_reg [6:8];
    cftp_pkg::pp_t   hhx_reg, hlx_reg, llx_reg, hhy_reg, hly_reg, lly_reg;
    cftp_pkg::dsq_t  dsq_reg [7:8];
    cftp_pkg::sq_t   sqnx_reg, sqny_reg;

    // stage 9 outputs
    cftp_pkg::side_t out_side_reg;
    cftp_pkg::num_t  num_reg [cftp_pkg::NLANE];
    cftp_pkg::den_t  den_reg [cftp_pkg::NLANE];

    logic [cftp_pkg::HALF_BITS-1:0] lox, loy;
    logic [cftp_pkg::HI_BITS-1:0]   hix, hiy;

    // Valid bits move with the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-1:1], in_valid};
        end
    end

    // Base point travels to the stage that builds the side word
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg[1] <= first_s;
            t1_reg[1] <= first_t;
            for (int k = 2; k <= 5; k++)
            begin
                s1_reg[k] <= s1_reg[k-1];
                t1_reg[k] <= t1_reg[k-1];
            end
        end
    end

    // Stages 1..5: differences, products, determinant, cross terms
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg[1] <= cftp_pkg::DIFF_BITS'(second_s) - cftp_pkg::DIFF_BITS'(first_s);
            ay_reg[1] <= cftp_pkg::DIFF_BITS'(second_t) - cftp_pkg::DIFF_BITS'(first_t);
            bx_reg[1] <= cftp_pkg::DIFF_BITS'(third_s) - cftp_pkg::DIFF_BITS'(first_s);
            by_reg[1] <= cftp_pkg::DIFF_BITS'(third_t) - cftp_pkg::DIFF_BITS'(first_t);
            for (int k = 2; k <= 3; k++)
            begin
                ax_reg[k] <= ax_reg[k-1];
                ay_reg[k] <= ay_reg[k-1];
                bx_reg[k] <= bx_reg[k-1];
                by_reg[k] <= by_reg[k-1];
            end

            axby_reg <= cftp_pkg::PROD_BITS'(ax_reg[1]) * cftp_pkg::PROD_BITS'(by_reg[1]);
            aybx_reg <= cftp_pkg::PROD_BITS'(ay_reg[1]) * cftp_pkg::PROD_BITS'(bx_reg[1]);
            sqax_reg <= cftp_pkg::PROD_BITS'(ax_reg[1]) * cftp_pkg::PROD_BITS'(ax_reg[1]);
            sqay_reg <= cftp_pkg::PROD_BITS'(ay_reg[1]) * cftp_pkg::PROD_BITS'(ay_reg[1]);
            sqbx_reg <= cftp_pkg::PROD_BITS'(bx_reg[1]) * cftp_pkg::PROD_BITS'(bx_reg[1]);
            sqby_reg <= cftp_pkg::PROD_BITS'(by_reg[1]) * cftp_pkg::PROD_BITS'(by_reg[1]);

            det_reg[3] <= cftp_pkg::DET_BITS'(axby_reg) - cftp_pkg::DET_BITS'(aybx_reg);
            la_reg     <= cftp_pkg::LEN_BITS'(sqax_reg + sqay_reg);
            lb_reg     <= cftp_pkg::LEN_BITS'(sqbx_reg + sqby_reg);

            byla_reg <= cftp_pkg::NX_BITS'(by_reg[3])
                        * cftp_pkg::NX_BITS'($signed({1'b0, la_reg}));
            aylb_reg <= cftp_pkg::NX_BITS'(ay_reg[3])
                        * cftp_pkg::NX_BITS'($signed({1'b0, lb_reg}));
            axlb_reg <= cftp_pkg::NX_BITS'(ax_reg[3])
                        * cftp_pkg::NX_BITS'($signed({1'b0, lb_reg}));
            bxla_reg <= cftp_pkg::NX_BITS'(bx_reg[3])
                        * cftp_pkg::NX_BITS'($signed({1'b0, la_reg}));
            det_reg[4] <= det_reg[3];

            nx_reg     <= byla_reg - aylb_reg;
            ny_reg     <= axlb_reg - bxla_reg;
            det_reg[5] <= det_reg[4];
        end
    end

    // Split the magnitudes for the squared numerators
    assign lox = mnx_reg[6][cftp_pkg::HALF_BITS-1:0];
    assign hix = mnx_reg[6][cftp_pkg::MAG_BITS-1:cftp_pkg::HALF_BITS];
    assign loy = mny_reg[6][cftp_pkg::HALF_BITS-1:0];
    assign hiy = mny_reg[6][cftp_pkg::MAG_BITS-1:cftp_pkg::HALF_BITS];

    // Stages 6..9: magnitudes, squares, lane operands
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[6].s1    <= s1_reg[5];
            side_reg[6].t1    <= t1_reg[5];
            side_reg[6].neg_s <= nx_reg[cftp_pkg::NX_BITS-1] ^ det_reg[5][cftp_pkg::DET_BITS-1];
            side_reg[6].neg_t <= ny_reg[cftp_pkg::NX_BITS-1] ^ det_reg[5][cftp_pkg::DET_BITS-1];
            side_reg[6].colin <= (det_reg[5] == '0);
            mnx_reg[6]  <= cftp_pkg::MAG_BITS'(nx_reg[cftp_pkg::NX_BITS-1] ? -nx_reg : nx_reg);
            mny_reg[6]  <= cftp_pkg::MAG_BITS'(ny_reg[cftp_pkg::NX_BITS-1] ? -ny_reg : ny_reg);
            mdet_reg[6] <= cftp_pkg::DMAG_BITS'(det_reg[5][cftp_pkg::DET_BITS-1] ?
                                                -det_reg[5] : det_reg[5]);

            hhx_reg <= cftp_pkg::PP_BITS'(hix) * cftp_pkg::PP_BITS'(hix);
            hlx_reg <= cftp_pkg::PP_BITS'(hix) * cftp_pkg::PP_BITS'(lox);
            llx_reg <= cftp_pkg::PP_BITS'(lox) * cftp_pkg::PP_BITS'(lox);
            hhy_reg <= cftp_pkg::PP_BITS'(hiy) * cftp_pkg::PP_BITS'(hiy);
            hly_reg <= cftp_pkg::PP_BITS'(hiy) * cftp_pkg::PP_BITS'(loy);
            lly_reg <= cftp_pkg::PP_BITS'(loy) * cftp_pkg::PP_BITS'(loy);
            dsq_reg[7] <= cftp_pkg::DSQ_BITS'(mdet_reg[6]) * cftp_pkg::DSQ_BITS'(mdet_reg[6]);
            side_reg[7] <= side_reg[6];
            mnx_reg[7]  <= mnx_reg[6];
            mny_reg[7]  <= mny_reg[6];
            mdet_reg[7] <= mdet_reg[6];

            sqnx_reg <= (cftp_pkg::SQ_BITS'(hhx_reg) << (2 * cftp_pkg::HALF_BITS))
                      + (cftp_pkg::SQ_BITS'(hlx_reg) << (cftp_pkg::HALF_BITS + 1))
                      + cftp_pkg::SQ_BITS'(llx_reg);
            sqny_reg <= (cftp_pkg::SQ_BITS'(hhy_reg) << (2 * cftp_pkg::HALF_BITS))
                      + (cftp_pkg::SQ_BITS'(hly_reg) << (cftp_pkg::HALF_BITS + 1))
                      + cftp_pkg::SQ_BITS'(lly_reg);
            dsq_reg[8]  <= dsq_reg[7];
            side_reg[8] <= side_reg[7];
            mnx_reg[8]  <= mnx_reg[7];
            mny_reg[8]  <= mny_reg[7];
            mdet_reg[8] <= mdet_reg[7];

            // center lanes: |n| * 2^F / (2|det|); radius lane: sum of squares / (4 det^2)
            out_side_reg <= side_reg[8];
            num_reg[cftp_pkg::LANE_S] <= cftp_pkg::NUM_BITS'(mnx_reg[8]) << cftp_pkg::FRAC_BITS;
            num_reg[cftp_pkg::LANE_T] <= cftp_pkg::NUM_BITS'(mny_reg[8]) << cftp_pkg::FRAC_BITS;
            num_reg[cftp_pkg::LANE_R] <= (cftp_pkg::NUM_BITS'(sqnx_reg)
                                          + cftp_pkg::NUM_BITS'(sqny_reg))
                                         << (2 * cftp_pkg::FRAC_BITS);
            den_reg[cftp_pkg::LANE_S] <= cftp_pkg::DEN_BITS'(mdet_reg[8]) << 1;
            den_reg[cftp_pkg::LANE_T] <= cftp_pkg::DEN_BITS'(mdet_reg[8]) << 1;
            den_reg[cftp_pkg::LANE_R] <= cftp_pkg::DEN_BITS'(dsq_reg[8]) << 2;
        end
    end

    assign out_valid = vld_reg[NSTG];
    assign out_side  = out_side_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;

endmodule

[src/cftp_div.sv]
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// Uses cftp_pkg; fed by cftp_front, drains into cftp_back.
module cftp_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cftp_pkg::side_t   in_side,
    input  cftp_pkg::num_t    in_num [cftp_pkg::NLANE],
    input  cftp_pkg::den_t    in_den [cftp_pkg::NLANE],
    output logic              out_valid,
    output cftp_pkg::side_t   out_side,
    output cftp_pkg::quo_t    out_quo [cftp_pkg::NLANE],
    output logic              out_rnz [cftp_pkg::NLANE],
    output logic              out_ovf [cftp_pkg::NLANE]
);

    localparam int NSTG = cftp_pkg::QUO_BITS;

    logic            vld_reg  [0:NSTG];
    cftp_pkg::side_t side_reg [0:NSTG];
    cftp_pkg::rem_t  rem_reg  [0:NSTG][cftp_pkg::NLANE];
    cftp_pkg::den_t  den_reg  [0:NSTG][cftp_pkg::NLANE];
    cftp_pkg::quo_t  quo_reg  [0:NSTG][cftp_pkg::NLANE];
    logic            ovf_reg  [0:NSTG][cftp_pkg::NLANE];

    // Load stage: quotient too wide when num / 2^Q >= den
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int l = 0; l < cftp_pkg::NLANE; l++)
            begin
                rem_reg[0][l] <= cftp_pkg::REM_BITS'(in_num[l]);
                den_reg[0][l] <= in_den[l];
                quo_reg[0][l] <= '0;
                ovf_reg[0][l] <= (cftp_pkg::REM_BITS'(in_num[l]) >> cftp_pkg::QUO_BITS)
                                 >= cftp_pkg::REM_BITS'(in_den[l]);
            end
        end
    end

    // One quotient bit per stage, MSB first
    for (genvar k = 0; k < NSTG; k++)
    begin : g_stage
        localparam int BIT = cftp_pkg::QUO_BITS - 1 - k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= side_reg[k];
            end
        end

        for (genvar l = 0; l < cftp_pkg::NLANE; l++)
        begin : g_lane
            logic [cftp_pkg::DEN_BITS:0] win;
            logic                        ge;
            cftp_pkg::rem_t              rem_next;
            cftp_pkg::quo_t              quo_next;

            // compare the aligned window against the divisor, subtract on success
            always_comb
            begin
                win      = rem_reg[k][l][BIT +: cftp_pkg::DEN_BITS+1];
                ge       = (win >= {1'b0, den_reg[k][l]});
                rem_next = rem_reg[k][l];
                quo_next = quo_reg[k][l];
                if (ge)
                begin
                    rem_next[BIT +: cftp_pkg::DEN_BITS+1] = win - {1'b0, den_reg[k][l]};
                    quo_next[BIT] = 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1][l] <= rem_next;
                    quo_reg[k+1][l] <= quo_next;
                    den_reg[k+1][l] <= den_reg[k][l];
                    ovf_reg[k+1][l] <= ovf_reg[k][l];
                end
            end
        end
    end

    assign out_valid = vld_reg[NSTG];
    assign out_side  = side_reg[NSTG];

    always_comb
    begin
        for (int l = 0; l < cftp_pkg::NLANE; l++)
        begin
            out_quo[l] = quo_reg[NSTG][l];
            out_rnz[l] = (rem_reg[NSTG][l] != '0);
            out_ovf[l] = ovf_reg[NSTG][l];
        end
    end

endmodule

[src/cftp_back.sv]
// Back end of the circle unit: center rounding and saturation, then a
// pipelined integer square root for the radius. Uses cftp_pkg.
module cftp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cftp_pkg::side_t   in_side,
    input  cftp_pkg::quo_t    in_quo [cftp_pkg::NLANE],
    input  logic              in_rnz [cftp_pkg::NLANE],
    input  logic              in_ovf [cftp_pkg::NLANE],
    output logic              out_valid,
    output cftp_pkg::res_t    out_res
);

    localparam int NSTG = cftp_pkg::ROOT_BITS;

    logic                          vld_reg   [0:NSTG];
    logic [cftp_pkg::OUT_BITS-1:0] cs_reg    [0:NSTG];
    logic [cftp_pkg::OUT_BITS-1:0] ct_reg    [0:NSTG];
    logic                          covf_reg  [0:NSTG];
    logic                          rovf_reg  [0:NSTG];
    logic                          colin_reg [0:NSTG];
    cftp_pkg::quo_t                x_reg     [0:NSTG];
    cftp_pkg::srem_t               srem_reg  [0:NSTG];
    cftp_pkg::root_t               root_reg  [0:NSTG];

    logic [cftp_pkg::OUT_BITS-1:0] cs_next, ct_next;
    logic                          sat_s, sat_t;

    // floor((base + n/(2d)) * 2^F), clamped to the signed result range
    function automatic logic [cftp_pkg::OUT_BITS:0] center_fix(
        input cftp_pkg::coord_t base,
        input cftp_pkg::quo_t   quo,
        input logic             rnz,
        input logic             ovf,
        input logic             neg
    );
        cftp_pkg::quo_t                       qm;
        logic signed [cftp_pkg::VAL_BITS-1:0] bf;
        logic signed [cftp_pkg::VAL_BITS-1:0] qs;
        logic signed [cftp_pkg::VAL_BITS-1:0] v;
        logic                                 sat;
        logic [cftp_pkg::OUT_BITS-1:0]        res;
        if (ovf || (quo >= cftp_pkg::QCLAMP))
            qm = cftp_pkg::QCLAMP;
        else
            qm = quo + cftp_pkg::QUO_BITS'(neg && rnz);
        bf  = cftp_pkg::VAL_BITS'(base) <<< cftp_pkg::FRAC_BITS;
        qs  = $signed(cftp_pkg::VAL_BITS'(qm));
        v   = neg ? (bf - qs) : (bf + qs);
        sat = (v[cftp_pkg::VAL_BITS-1:cftp_pkg::OUT_BITS-1] != '0)
           && (v[cftp_pkg::VAL_BITS-1:cftp_pkg::OUT_BITS-1] != '1);
        if (!sat)
            res = v[cftp_pkg::OUT_BITS-1:0];
        else if (v[cftp_pkg::VAL_BITS-1])
            res = {1'b1, {(cftp_pkg::OUT_BITS-1){1'b0}}};
        else
            res = {1'b0, {(cftp_pkg::OUT_BITS-1){1'b1}}};
        return {sat, res};
    endfunction

    // Center lanes finish here
    always_comb
    begin
        {sat_s, cs_next} = center_fix(in_side.s1, in_quo[cftp_pkg::LANE_S],
                                      in_rnz[cftp_pkg::LANE_S], in_ovf[cftp_pkg::LANE_S],
                                      in_side.neg_s);
        {sat_t, ct_next} = center_fix(in_side.t1, in_quo[cftp_pkg::LANE_T],
                                      in_rnz[cftp_pkg::LANE_T], in_ovf[cftp_pkg::LANE_T],
                                      in_side.neg_t);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs_reg[0]    <= cs_next;
            ct_reg[0]    <= ct_next;
            covf_reg[0]  <= sat_s | sat_t;
            rovf_reg[0]  <= in_ovf[cftp_pkg::LANE_R];
            colin_reg[0] <= in_side.colin;
            x_reg[0]     <= in_quo[cftp_pkg::LANE_R];
            srem_reg[0]  <= '0;
            root_reg[0]  <= '0;
        end
    end

    // Square root, one result bit per stage
    for (genvar j = 0; j < NSTG; j++)
    begin : g_root
        localparam int TOP = cftp_pkg::QUO_BITS - 1 - 2 * j;

        cftp_pkg::srem_t sh;
        cftp_pkg::srem_t trial;
        cftp_pkg::srem_t srem_next;
        cftp_pkg::root_t root_next;

        always_comb
        begin
            sh    = {srem_reg[j][cftp_pkg::SREM_BITS-3:0], x_reg[j][TOP -: 2]};
            trial = cftp_pkg::SREM_BITS'({root_reg[j], 2'b01});
            if (sh >= trial)
            begin
                srem_next = sh - trial;
                root_next = {root_reg[j][cftp_pkg::ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                srem_next = sh;
                root_next = {root_reg[j][cftp_pkg::ROOT_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cs_reg[j+1]    <= cs_reg[j];
                ct_reg[j+1]    <= ct_reg[j];
                covf_reg[j+1]  <= covf_reg[j];
                rovf_reg[j+1]  <= rovf_reg[j];
                colin_reg[j+1] <= colin_reg[j];
                x_reg[j+1]     <= x_reg[j];
                srem_reg[j+1]  <= srem_next;
                root_reg[j+1]  <= root_next;
            end
        end
    end

    // Assemble the result word; colinear points set the colinear flag and zero all other fields
    always_comb
    begin
        out_res = '0;
        if (colin_reg[NSTG])
        begin
            out_res.colin = 1'b1;
        end
        else
        begin
            out_res.center_s = cs_reg[NSTG];
            out_res.center_t = ct_reg[NSTG];
            out_res.radius   = rovf_reg[NSTG] ? '1 : cftp_pkg::OUT_BITS'(root_reg[NSTG]);
            out_res.ovf      = covf_reg[NSTG] | rovf_reg[NSTG];
        end
    end

    assign out_valid = vld_reg[NSTG];

endmodule

[src/circle_from_three_points_unit.sv]
// Top level of the three-point circle unit: front end, divider, root stage
// and the output register with its skid word. Uses cftp_pkg and all cftp_ modules.
//
// Takes three points with signed 12-bit coordinates and returns the circle
// through them: center (signed) and radius (unsigned) in fixed point with 8
// fractional bits, floor-rounded, saturated with the overflow flag set, or
// the colinear flag with all other fields zero. One word enters per cycle and
// one result leaves per cycle in steady state, unless input stalls. The path
// from acceptance to the result register runs through 9 front-end stages, 65
// divider stages (a load stage, then one quotient bit each for a 64-bit
// quotient) and 33 back-end stages (center finish, then one root bit each for
// a 32-bit root), plus the output register. A skid word behind the output register
// keeps input flowing while a result waits; input stalls only when both are full.
module circle_from_three_points_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cftp_pkg::coord_t       first_s,
    input  cftp_pkg::coord_t       first_t,
    input  cftp_pkg::coord_t       second_s,
    input  cftp_pkg::coord_t       second_t,
    input  cftp_pkg::coord_t       third_s,
    input  cftp_pkg::coord_t       third_t,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [31:0]     center_s,
    output logic signed [31:0]     center_t,
    output logic [31:0]            circle_radius,
    output logic                   colinear,
    output logic                   overflow
);

    logic            en;
    logic            fr_valid, dv_valid, bk_valid;
    cftp_pkg::side_t fr_side, dv_side;
    cftp_pkg::num_t  fr_num [cftp_pkg::NLANE];
    cftp_pkg::den_t  fr_den [cftp_pkg::NLANE];
    cftp_pkg::quo_t  dv_quo [cftp_pkg::NLANE];
    logic            dv_rnz [cftp_pkg::NLANE];
    logic            dv_ovf [cftp_pkg::NLANE];
    cftp_pkg::res_t  bk_res;

    logic            out_valid_reg, skid_valid_reg;
    cftp_pkg::res_t  out_res_reg, skid_res_reg;
    logic            arrive, take;

    // Whole pipeline moves unless the skid word is occupied
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    cftp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .first_s   (first_s),
        .first_t   (first_t),
        .second_s  (second_s),
        .second_t  (second_t),
        .third_s   (third_s),
        .third_t   (third_t),
        .out_valid (fr_valid),
        .out_side  (fr_side),
        .out_num   (fr_num),
        .out_den   (fr_den)
    );

    cftp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_num    (fr_num),
        .in_den    (fr_den),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo),
        .out_rnz   (dv_rnz),
        .out_ovf   (dv_ovf)
    );

    cftp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .in_side   (dv_side),
        .in_quo    (dv_quo),
        .in_rnz    (dv_rnz),
        .in_ovf    (dv_ovf),
        .out_valid (bk_valid),
        .out_res   (bk_res)
    );

    assign arrive = en && bk_valid;
    assign take   = out_valid_reg && out_ready;

    // Output register and skid word control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_reg <= arrive;
        end
        else if (arrive)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output register and skid word data
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_res_reg <= skid_res_reg;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_res_reg <= bk_res;
        end
        else
        begin
            skid_res_reg <= bk_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign center_s      = $signed(out_res_reg.center_s);
    assign center_t      = $signed(out_res_reg.center_t);
    assign circle_radius = out_res_reg.radius;
    assign colinear      = out_res_reg.colin;
    assign overflow      = out_res_reg.ovf;

endmodule
